>>> hdl/small_priority_event_queue_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the small priority event queue
// Shared property wrappers; clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SMALL_PRIORITY_EVENT_QUEUE_CORE_ASSERT_SVH
`define SMALL_PRIORITY_EVENT_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define SEPQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sepq assertion failed");

// next-cycle implication
`define SEPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sepq assertion failed");

`endif

>>> hdl/sepq_pkg.sv
// ---------------------------------------------------------------------------
// sepq_pkg
// Shared types and defaults for the small priority event queue.
// ---------------------------------------------------------------------------
package sepq_pkg;

	localparam int unsigned SLOTS_DEF     = 4;
	localparam int unsigned TAG_BITS_DEF  = 8;
	localparam int unsigned PRIO_BITS_DEF = 8;

	typedef enum logic {
		ACT_POST = 1'b0,
		ACT_TAKE = 1'b1
	} act_t;

	// result tuser bit positions
	localparam int unsigned USR_POST_ACC = 0;
	localparam int unsigned USR_EVT_VLD  = 1;

	// row-wide command, one per accepted beat
	typedef struct packed {
		logic post;
		logic take;
	} cell_cmd_t;

	// status a cell hands to its right neighbor
	typedef struct packed {
		logic used;
		logic gt;
	} cell_ctl_t;

endpackage

>>> hdl/sepq_cell.sv
// ---------------------------------------------------------------------------
// sepq_cell
// One queue slot. Holds an entry and compares it with the event being posted;
// inserts, shifts right on insert, or shifts left on take.
// ---------------------------------------------------------------------------
`include "small_priority_event_queue_core_assert.svh"

module sepq_cell #(
	parameter int unsigned TAG_BITS  = sepq_pkg::TAG_BITS_DEF,
	parameter int unsigned PRIO_BITS = sepq_pkg::PRIO_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sepq_pkg::cell_cmd_t         cmd,
	input  logic [TAG_BITS-1:0]         new_tag,
	input  logic signed [PRIO_BITS-1:0] new_prio,
	input  sepq_pkg::cell_ctl_t         lft,
	input  logic [TAG_BITS-1:0]         lft_tag,
	input  logic signed [PRIO_BITS-1:0] lft_prio,
	input  logic                        rgt_used,
	input  logic [TAG_BITS-1:0]         rgt_tag,
	input  logic signed [PRIO_BITS-1:0] rgt_prio,
	output sepq_pkg::cell_ctl_t         ctl,
	output logic [TAG_BITS-1:0]         tag,
	output logic signed [PRIO_BITS-1:0] prio
);
	import sepq_pkg::*;

	logic                        used_q;
	logic [TAG_BITS-1:0]         tag_q;
	logic signed [PRIO_BITS-1:0] prio_q;
	logic                        ins_new;

	assign ctl.used = used_q;
	assign ctl.gt   = used_q && (prio_q > new_prio);
	assign tag      = tag_q;
	assign prio     = prio_q;

	// new entry lands after all entries of lower or equal priority
	assign ins_new = lft.used && !lft.gt && (ctl.gt || !used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.take) begin
			used_q <= rgt_used;
		end else if (cmd.post && (lft.gt || ins_new)) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			tag_q  <= rgt_tag;
			prio_q <= rgt_prio;
		end else if (cmd.post && lft.gt) begin
			tag_q  <= lft_tag;
			prio_q <= lft_prio;
		end else if (cmd.post && ins_new) begin
			tag_q  <= new_tag;
			prio_q <= new_prio;
		end
	end

	`SEPQ_ASSERT_IMPL(a_sorted, used_q && lft.used, lft_prio <= prio_q)
	`SEPQ_ASSERT_IMPL(a_compact, used_q, lft.used)
	`SEPQ_ASSERT_NEXT(a_post_keeps, cmd.post && used_q, used_q)

endmodule

>>> hdl/small_priority_event_queue_core.sv
// ---------------------------------------------------------------------------
// small_priority_event_queue_core
// Priority event queue built as a sorted row of slot cells.
// ---------------------------------------------------------------------------
// Takes one beat per clock: post (tuser 0) stores tag and signed priority if a
// slot is free, take (tuser 1) returns the entry with the lowest priority,
// oldest first on ties. Every beat gives exactly one result beat in the next
// cycle through an output register; a new beat is taken while that register
// is empty or being drained, so the sustained rate is one beat per cycle,
// set by the insert or shift that all SLOTS cells of the row do together.
`include "small_priority_event_queue_core_assert.svh"

module small_priority_event_queue_core #(
	parameter int unsigned SLOTS         = sepq_pkg::SLOTS_DEF,
	parameter int unsigned TAG_BITS      = sepq_pkg::TAG_BITS_DEF,
	parameter int unsigned PRIORITY_BITS = sepq_pkg::PRIO_BITS_DEF,
	localparam int unsigned DATA_W       = ((TAG_BITS + PRIORITY_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // event_tag, priority_req
	input  logic [0:0]        s_axis_tuser,  // action
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // out_tag, out_priority
	output logic [1:0]        m_axis_tuser   // post_accepted, event_valid
);
	import sepq_pkg::*;

	logic                            in_acc;
	act_t                            act;
	logic [TAG_BITS-1:0]             in_tag;
	logic signed [PRIORITY_BITS-1:0] in_prio;
	cell_cmd_t                       cmd;
	logic                            full;
	logic                            empty;

	cell_ctl_t                       ctl_arr [SLOTS];
	logic [TAG_BITS-1:0]             tag_arr [SLOTS];
	logic signed [PRIORITY_BITS-1:0] prio_arr [SLOTS];
	logic [SLOTS-1:0]                used_vec;

	logic                            out_vld_q;
	logic [1:0]                      out_usr_q;
	logic [DATA_W-1:0]               out_dat_q;

	assign s_axis_tready = !out_vld_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign act           = act_t'(s_axis_tuser[0]);
	assign in_tag        = s_axis_tdata[TAG_BITS-1:0];
	assign in_prio       = s_axis_tdata[TAG_BITS+PRIORITY_BITS-1:TAG_BITS];

	assign full     = used_vec[SLOTS-1];
	assign empty    = !used_vec[0];
	assign cmd.post = in_acc && (act == ACT_POST) && !full;
	assign cmd.take = in_acc && (act == ACT_TAKE) && !empty;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		cell_ctl_t                       l_ctl;
		logic [TAG_BITS-1:0]             l_tag;
		logic signed [PRIORITY_BITS-1:0] l_prio;
		logic                            r_used;
		logic [TAG_BITS-1:0]             r_tag;
		logic signed [PRIORITY_BITS-1:0] r_prio;

		if (i == 0) begin : g_head
			assign l_ctl  = '{used: 1'b1, gt: 1'b0};
			assign l_tag  = '0;
			assign l_prio = {1'b1, {(PRIORITY_BITS-1){1'b0}}};
		end else begin : g_body
			assign l_ctl  = ctl_arr[i-1];
			assign l_tag  = tag_arr[i-1];
			assign l_prio = prio_arr[i-1];
		end

		if (i == SLOTS - 1) begin : g_tail
			assign r_used = 1'b0;
			assign r_tag  = '0;
			assign r_prio = '0;
		end else begin : g_inner
			assign r_used = ctl_arr[i+1].used;
			assign r_tag  = tag_arr[i+1];
			assign r_prio = prio_arr[i+1];
		end

		sepq_cell #(
			.TAG_BITS  (TAG_BITS),
			.PRIO_BITS (PRIORITY_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.new_tag  (in_tag),
			.new_prio (in_prio),
			.lft      (l_ctl),
			.lft_tag  (l_tag),
			.lft_prio (l_prio),
			.rgt_used (r_used),
			.rgt_tag  (r_tag),
			.rgt_prio (r_prio),
			.ctl      (ctl_arr[i]),
			.tag      (tag_arr[i]),
			.prio     (prio_arr[i])
		);

		assign used_vec[i] = ctl_arr[i].used;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_acc) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_usr_q[USR_POST_ACC] <= cmd.post;
			out_usr_q[USR_EVT_VLD]  <= cmd.take;
			if (cmd.take) begin
				out_dat_q <= DATA_W'({prio_arr[0], tag_arr[0]});
			end else begin
				out_dat_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_usr_q;
	assign m_axis_tdata  = out_dat_q;

	`SEPQ_ASSERT_IMPL(a_used_thermo, 1'b1, (used_vec & (used_vec + SLOTS'(1))) == '0)
	`SEPQ_ASSERT_NEXT(a_post_grows, cmd.post, used_vec == {$past(used_vec[SLOTS-2:0]), 1'b1})
	`SEPQ_ASSERT_NEXT(a_take_shrinks, cmd.take, used_vec == ($past(used_vec) >> 1))
	`SEPQ_ASSERT_NEXT(a_empty_take, in_acc && act == ACT_TAKE && empty,
		!m_axis_tuser[USR_EVT_VLD] && m_axis_tdata == '0)
	`SEPQ_ASSERT_NEXT(a_result_follows, in_acc, m_axis_tvalid)

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb: small priority event queue core
// Streams post and take beats through the queue and checks every result beat
// against a shadow queue kept in posting order. Covers the empty and full
// cases, signed priority extremes and ties, with bursty input and a stalling
// output.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sepq_pkg::*;

	localparam int SLOTS          = SLOTS_DEF;
	localparam int TAG_W          = TAG_BITS_DEF;
	localparam int PRI_W          = PRIO_BITS_DEF;
	localparam int DATA_W         = ((TAG_W + PRI_W + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 1330;

	typedef struct {
		act_t                    act;
		logic [TAG_W-1:0]        tag;
		logic signed [PRI_W-1:0] pri;
		bit                      drain;
	} evq_item_t;

	typedef struct {
		logic                    post_ok;
		logic                    evt_ok;
		logic [TAG_W-1:0]        tag;
		logic signed [PRI_W-1:0] pri;
	} evq_result_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata  = '0;
	logic [0:0]        s_axis_tuser  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic [1:0]        m_axis_tuser;

	evq_item_t   stim_items[$];
	evq_result_t due_results[$];

	logic [TAG_W-1:0]        shadow_tag[SLOTS];
	logic signed [PRI_W-1:0] shadow_pri[SLOTS];
	int                      shadow_fill = 0;

	int mismatches    = 0;
	int posts_stored  = 0;
	int posts_refused = 0;
	int takes_served  = 0;
	int takes_empty   = 0;
	int idle_cycles   = 0;
	int burst_left    = 1;
	int gap_left      = 0;
	int ready_mode    = 0;
	int ready_left    = 0;

	small_priority_event_queue_core #(
		.SLOTS        (SLOTS),
		.TAG_BITS     (TAG_W),
		.PRIORITY_BITS(PRI_W)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lowest priority wins, oldest first on ties; entries kept in posting order
	function automatic evq_result_t step_shadow_queue(act_t act, logic [TAG_W-1:0] tag,
	                                                  logic signed [PRI_W-1:0] pri);
		evq_result_t res;
		int          best;
		res = '{post_ok: 1'b0, evt_ok: 1'b0, tag: '0, pri: '0};
		if (act == ACT_POST) begin
			if (shadow_fill < SLOTS) begin
				shadow_tag[shadow_fill] = tag;
				shadow_pri[shadow_fill] = pri;
				shadow_fill++;
				res.post_ok = 1'b1;
			end
			return res;
		end
		if (shadow_fill == 0)
			return res;
		best = 0;
		for (int i = 1; i < shadow_fill; i++)
			if (shadow_pri[i] < shadow_pri[best])
				best = i;
		res.evt_ok = 1'b1;
		res.tag    = shadow_tag[best];
		res.pri    = shadow_pri[best];
		for (int i = best; i < shadow_fill - 1; i++) begin
			shadow_tag[i] = shadow_tag[i + 1];
			shadow_pri[i] = shadow_pri[i + 1];
		end
		shadow_fill--;
		return res;
	endfunction

	task automatic plan_item(act_t act, logic [TAG_W-1:0] tag, logic signed [PRI_W-1:0] pri,
	                         bit drain);
		evq_item_t it;
		it.act   = act;
		it.tag   = tag;
		it.pri   = pri;
		it.drain = drain;
		stim_items.push_back(it);
	endtask

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (mismatches < 100)
			$display("mismatch %s: got %0h, expected %0h at %0t ns", field, got, want, $time);
		mismatches++;
	endtask

	// driver: bursts with random gaps, valid held until the beat goes through
	always @(posedge clk or negedge arst_n) begin : driver
		logic drive;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (act_t'(s_axis_tuser[0]) == ACT_POST && shadow_fill == SLOTS)
					posts_refused++;
				if (act_t'(s_axis_tuser[0]) == ACT_TAKE && shadow_fill == 0)
					takes_empty++;
				due_results.push_back(step_shadow_queue(act_t'(s_axis_tuser[0]),
					s_axis_tdata[TAG_W-1:0], s_axis_tdata[TAG_W+PRI_W-1:TAG_W]));
				void'(stim_items.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				drive = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_items.size() != 0 &&
				             !(stim_items[0].drain && due_results.size() != 0)) begin
					drive = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
				s_axis_tvalid <= drive;
				if (drive) begin
					s_axis_tdata <= {stim_items[0].pri, stim_items[0].tag};
					s_axis_tuser <= stim_items[0].act;
				end
			end
		end
	end

	// monitor: checks each result beat, ready follows its own stall pattern
	always @(posedge clk or negedge arst_n) begin : monitor
		evq_result_t want;
		logic        rdy;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected beat", 32'(m_axis_tdata), '0);
				end else begin
					want = due_results.pop_front();
					if (m_axis_tuser[USR_POST_ACC] !== want.post_ok)
						report_mismatch("post_accepted", 32'(m_axis_tuser[USR_POST_ACC]),
							32'(want.post_ok));
					if (m_axis_tuser[USR_EVT_VLD] !== want.evt_ok)
						report_mismatch("event_valid", 32'(m_axis_tuser[USR_EVT_VLD]),
							32'(want.evt_ok));
					if (m_axis_tdata[TAG_W-1:0] !== want.tag)
						report_mismatch("out_tag", 32'(m_axis_tdata[TAG_W-1:0]), 32'(want.tag));
					if (m_axis_tdata[TAG_W+PRI_W-1:TAG_W] !== want.pri)
						report_mismatch("out_priority", 32'(m_axis_tdata[TAG_W+PRI_W-1:TAG_W]),
							32'($unsigned(want.pri)));
					if (want.post_ok)
						posts_stored++;
					else if (want.evt_ok)
						takes_served++;
				end
			end
			if (ready_left <= 0) begin
				ready_mode = $urandom_range(0, 3);
				ready_left = $urandom_range(16, 96);
			end
			ready_left--;
			case (ready_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 4) == 0);
				default: rdy = (ready_left % 4) != 0;
			endcase
			m_axis_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", idle_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int          style;
		int          pri_style;
		int          post_pct;
		logic signed [PRI_W-1:0] pri;

		// empty take, extremes, tie, full queue
		plan_item(ACT_TAKE, 8'h00, 8'sh00, 1'b0);
		plan_item(ACT_POST, 8'h00, 8'sh7f, 1'b0);
		plan_item(ACT_POST, 8'hff, -8'sd128, 1'b0);
		plan_item(ACT_POST, 8'h5a, 8'sh00, 1'b0);
		plan_item(ACT_POST, 8'ha5, 8'sh00, 1'b0);
		plan_item(ACT_POST, 8'h11, -8'sd1, 1'b0);
		plan_item(ACT_TAKE, 8'hff, 8'sh7f, 1'b0);
		plan_item(ACT_TAKE, 8'h00, -8'sd128, 1'b0);
		plan_item(ACT_POST, 8'h33, 8'sh00, 1'b1);
		plan_item(ACT_TAKE, 8'h00, 8'sh00, 1'b0);
		plan_item(ACT_TAKE, 8'h00, 8'sh00, 1'b0);
		plan_item(ACT_TAKE, 8'h00, 8'sh00, 1'b0);
		plan_item(ACT_TAKE, 8'h00, 8'sh00, 1'b0);
		for (int i = 1; i <= SLOTS; i++)
			plan_item(ACT_POST, 8'(i), 8'sh7f, 1'b0);
		for (int i = 0; i <= SLOTS; i++)
			plan_item(ACT_TAKE, 8'h00, 8'sh00, 1'b0);

		style     = 0;
		pri_style = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				style     = $urandom_range(0, 3);
				pri_style = $urandom_range(0, 2);
			end
			case (style)
				0: post_pct = 70;
				1: post_pct = 30;
				2: post_pct = 50;
				default: post_pct = 90;
			endcase
			case (pri_style)
				0: pri = PRI_W'($urandom);
				1: pri = PRI_W'($urandom_range(0, 4)) - PRI_W'(2);
				default: begin
					case ($urandom_range(0, 5))
						0: pri = -8'sd128;
						1: pri = -8'sd127;
						2: pri = 8'sh7e;
						3: pri = 8'sh7f;
						4: pri = -8'sd1;
						default: pri = 8'sh00;
					endcase
				end
			endcase
			plan_item(($urandom_range(0, 99) < post_pct) ? ACT_POST : ACT_TAKE,
				TAG_W'($urandom), pri, (n % 250) == 125);
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (stim_items.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d posts stored, %0d refused on a full queue,",
			posts_stored, posts_refused);
		$display("%0d events served and %0d takes on an empty queue; %0d mismatches",
			takes_served, takes_empty, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
